// ===== hw/rtl/sle_pkg.sv =====
// Shared types, codes and constants of the serial line editor.
package sle_pkg;

  // Default line capacity; the store holds one byte fewer
  localparam int LineCapacityDefault = 32;

  // Byte codes
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChDel   = 8'h7F;

  // Result kinds
  localparam logic [1:0] KindEcho     = 2'd0;
  localparam logic [1:0] KindLine     = 2'd1;
  localparam logic [1:0] KindEmpty    = 2'd2;
  localparam logic [1:0] KindOverflow = 2'd3;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ECHO,
    S_BS1,
    S_BS2,
    S_BS3,
    S_CR,
    S_LF,
    S_SCAN,
    S_OVF,
    S_EMPTY,
    S_RD,
    S_PUT
  } state_t;

  // Source of the result byte
  typedef enum logic [2:0] {
    SEL_RX,
    SEL_CR,
    SEL_LF,
    SEL_BS,
    SEL_SP,
    SEL_LINE,
    SEL_ZERO
  } sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       take;
    logic       push;
    logic       pop;
    logic       set_ovf;
    logic       put;
    logic [1:0] put_kind;
    sel_t       put_sel;
    logic       put_last;
    logic       clear_line;
    logic       scan_init;
    logic       scan_step;
    logic       emit_load;
    logic       emit_rd;
    logic       emit_next;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_lf;
    logic is_cr;
    logic is_bs;
    logic is_print;
    logic after_cr;
    logic ovf;
    logic len_zero;
    logic full;
    logic slot_free;
    logic scan_done;
    logic found;
    logic emit_last;
  } status_t;

endpackage

// ===== hw/rtl/sle_ctrl.sv =====
// Controller state machine of the serial line editor.
module sle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sle_pkg::status_t st,
  output sle_pkg::cmd_t    cmd
);

  sle_pkg::state_t state;
  sle_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::S_IDLE: begin
        if (in_valid) begin
          if (st.is_cr || (st.is_lf && !st.after_cr)) begin
            state_next = sle_pkg::S_CR;
          end else if (st.is_bs && !st.ovf && !st.len_zero) begin
            state_next = sle_pkg::S_BS1;
          end else if (st.is_print && !st.ovf && !st.full) begin
            state_next = sle_pkg::S_ECHO;
          end
        end
      end
      sle_pkg::S_ECHO: if (st.slot_free) state_next = sle_pkg::S_IDLE;
      sle_pkg::S_BS1:  if (st.slot_free) state_next = sle_pkg::S_BS2;
      sle_pkg::S_BS2:  if (st.slot_free) state_next = sle_pkg::S_BS3;
      sle_pkg::S_BS3:  if (st.slot_free) state_next = sle_pkg::S_IDLE;
      sle_pkg::S_CR:   if (st.slot_free) state_next = sle_pkg::S_LF;
      sle_pkg::S_LF: begin
        if (st.slot_free) begin
          state_next = st.ovf ? sle_pkg::S_OVF : sle_pkg::S_SCAN;
        end
      end
      sle_pkg::S_SCAN: begin
        if (st.scan_done) begin
          state_next = st.found ? sle_pkg::S_RD : sle_pkg::S_EMPTY;
        end
      end
      sle_pkg::S_OVF:   if (st.slot_free) state_next = sle_pkg::S_IDLE;
      sle_pkg::S_EMPTY: if (st.slot_free) state_next = sle_pkg::S_IDLE;
      sle_pkg::S_RD:    state_next = sle_pkg::S_PUT;
      sle_pkg::S_PUT: begin
        if (st.slot_free) begin
          state_next = st.emit_last ? sle_pkg::S_IDLE : sle_pkg::S_RD;
        end
      end
      default: state_next = sle_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.put_sel  = sle_pkg::SEL_ZERO;
    cmd.put_kind = sle_pkg::KindEcho;
    in_stall     = (state != sle_pkg::S_IDLE);
    case (state)
      sle_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.take    = 1'b1;
          cmd.push    = st.is_print && !st.ovf && !st.full;
          cmd.set_ovf = st.is_print && (st.ovf || st.full);
          cmd.pop     = st.is_bs && !st.ovf && !st.len_zero;
        end
      end
      sle_pkg::S_ECHO: begin
        cmd.put      = st.slot_free;
        cmd.put_sel  = sle_pkg::SEL_RX;
        cmd.put_last = 1'b1;
      end
      sle_pkg::S_BS1: begin
        cmd.put     = st.slot_free;
        cmd.put_sel = sle_pkg::SEL_BS;
      end
      sle_pkg::S_BS2: begin
        cmd.put     = st.slot_free;
        cmd.put_sel = sle_pkg::SEL_SP;
      end
      sle_pkg::S_BS3: begin
        cmd.put      = st.slot_free;
        cmd.put_sel  = sle_pkg::SEL_BS;
        cmd.put_last = 1'b1;
      end
      sle_pkg::S_CR: begin
        cmd.put     = st.slot_free;
        cmd.put_sel = sle_pkg::SEL_CR;
      end
      sle_pkg::S_LF: begin
        cmd.put       = st.slot_free;
        cmd.put_sel   = sle_pkg::SEL_LF;
        cmd.scan_init = st.slot_free;
      end
      sle_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.emit_load = st.scan_done;
      end
      sle_pkg::S_OVF: begin
        cmd.put        = st.slot_free;
        cmd.put_kind   = sle_pkg::KindOverflow;
        cmd.put_last   = 1'b1;
        cmd.clear_line = st.slot_free;
      end
      sle_pkg::S_EMPTY: begin
        cmd.put        = st.slot_free;
        cmd.put_kind   = sle_pkg::KindEmpty;
        cmd.put_last   = 1'b1;
        cmd.clear_line = st.slot_free;
      end
      sle_pkg::S_RD: begin
        cmd.emit_rd = 1'b1;
      end
      sle_pkg::S_PUT: begin
        cmd.put        = st.slot_free;
        cmd.put_kind   = sle_pkg::KindLine;
        cmd.put_sel    = sle_pkg::SEL_LINE;
        cmd.put_last   = st.emit_last;
        cmd.emit_next  = st.slot_free;
        cmd.clear_line = st.slot_free && st.emit_last;
      end
      default: begin
        cmd.put_sel = sle_pkg::SEL_ZERO;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sle_datapath.sv =====
// Datapath of the serial line editor: line store, trim scan and output register.
module sle_datapath #(
  parameter int LINE_CAPACITY = sle_pkg::LineCapacityDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       rx_byte,
  input  sle_pkg::cmd_t    cmd,
  output sle_pkg::status_t st,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             is_last
);

  localparam int StoreDepth = LINE_CAPACITY - 1;
  localparam int LenW       = $clog2(LINE_CAPACITY);
  localparam int IdxW       = $clog2(StoreDepth);
  localparam logic [LenW-1:0] LenFull = LenW'(StoreDepth);

  logic [7:0]      line_mem [StoreDepth];
  logic [7:0]      rd_data;
  logic [7:0]      cur_byte;
  logic [LenW-1:0] line_length;
  logic            overflow_seen;
  logic            after_cr;
  logic [LenW-1:0] scan_addr;
  logic [IdxW-1:0] scan_idx;
  logic            scan_pend;
  logic            found;
  logic [IdxW-1:0] first_idx;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] emit_addr;
  logic            scan_rd;
  logic            slot_free;
  logic [7:0]      put_byte;

  assign slot_free = !out_valid || !out_stall;
  assign scan_rd   = cmd.scan_step && (scan_addr != line_length);

  // Status towards the controller
  always_comb begin
    st           = '0;
    st.is_lf     = (rx_byte == sle_pkg::ChLf);
    st.is_cr     = (rx_byte == sle_pkg::ChCr);
    st.is_bs     = (rx_byte == sle_pkg::ChBs) || (rx_byte == sle_pkg::ChDel);
    st.is_print  = (rx_byte >= sle_pkg::ChSpace) && (rx_byte <= sle_pkg::ChTilde);
    st.after_cr  = after_cr;
    st.ovf       = overflow_seen;
    st.len_zero  = (line_length == '0);
    st.full      = (line_length == LenFull);
    st.slot_free = slot_free;
    st.scan_done = (scan_addr == line_length) && !scan_pend;
    st.found     = found;
    st.emit_last = (emit_addr == last_idx);
  end

  // Line store: write on append, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      line_mem[line_length[IdxW-1:0]] <= rx_byte;
    end
    if (scan_rd) begin
      rd_data <= line_mem[scan_addr[IdxW-1:0]];
    end else if (cmd.emit_rd) begin
      rd_data <= line_mem[emit_addr];
    end
  end

  // Line length and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      overflow_seen <= 1'b0;
      after_cr      <= 1'b0;
    end else begin
      if (cmd.take) begin
        after_cr <= (rx_byte == sle_pkg::ChCr);
      end
      if (cmd.clear_line) begin
        line_length   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (cmd.push) begin
          line_length <= line_length + 1'b1;
        end else if (cmd.pop) begin
          line_length <= line_length - 1'b1;
        end
        if (cmd.set_ovf) begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // Hold the accepted byte for its echo
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_byte <= rx_byte;
    end
  end

  // Trim scan: find the first and last stored byte that is not a space
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
      scan_addr <= '0;
      found     <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_pend <= 1'b0;
      scan_addr <= '0;
      found     <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_pend <= scan_rd;
      if (scan_rd) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (scan_pend && (rd_data != sle_pkg::ChSpace)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_addr[IdxW-1:0];
    if (cmd.scan_step && scan_pend && (rd_data != sle_pkg::ChSpace)) begin
      if (!found) begin
        first_idx <= scan_idx;
      end
      last_idx <= scan_idx;
    end
  end

  // Advance the emit pointer through the trimmed line
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      emit_addr <= first_idx;
    end else if (cmd.emit_next) begin
      emit_addr <= emit_addr + 1'b1;
    end
  end

  // Pick the result byte
  always_comb begin
    case (cmd.put_sel)
      sle_pkg::SEL_RX:   put_byte = cur_byte;
      sle_pkg::SEL_CR:   put_byte = sle_pkg::ChCr;
      sle_pkg::SEL_LF:   put_byte = sle_pkg::ChLf;
      sle_pkg::SEL_BS:   put_byte = sle_pkg::ChBs;
      sle_pkg::SEL_SP:   put_byte = sle_pkg::ChSpace;
      sle_pkg::SEL_LINE: put_byte = rd_data;
      default:           put_byte = 8'h00;
    endcase
  end

  // Output register: load a beat when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_kind <= cmd.put_kind;
      out_byte <= put_byte;
      is_last  <= cmd.put_last;
    end
  end

endmodule

// ===== hw/rtl/serial_line_editor_unit.sv =====
// Top level of the serial line editor.
//
// Input channel: rx_byte with in_valid / in_stall; a beat is taken at a rising
// edge with in_valid high and in_stall low. Output channel: out_kind, out_byte
// and is_last with out_valid / out_stall, one result per beat; is_last marks
// the final result caused by an input byte.
// One byte is worked on at a time: in_stall is high from the beat until the
// byte's last result sits in the output register. That register holds a
// finished beat, so the next byte is taken while the receiver still stalls.
// Printable byte: echo goes out via the ECHO state; backspace gives
// three beats, one cycle each when the receiver takes them.
// Line end (CR, or LF not after CR; trimmed length T): CR and LF beats, then
// an overflowed line gives an overflow result; any other line is trimmed by a
// scan over the line store, then gives T line bytes, each by a registered
// store read and then an output load, or an empty result if it holds nothing but spaces.
// A stalled receiver holds the controller in its current result step.
// Reset (rst, synchronous) empties the line and clears the overflow and
// carriage-return flags; the store contents need no clearing.
module serial_line_editor_unit #(
  parameter int LINE_CAPACITY = sle_pkg::LineCapacityDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       is_last
);

  sle_pkg::cmd_t    cmd;
  sle_pkg::status_t st;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sle_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .is_last   (is_last)
  );

endmodule
